[design/crv_pkg.sv]
// Shared types and constants for the comb/allpass reverberator.
// Used by comb_allpass_reverb_top, crv_glide and crv_checker; depends on nothing.

package crv_pkg;

  // Configuration port geometry.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_WET_MIX   = 2'd1,
    REG_ROOM_SIZE = 2'd2,
    REG_DAMPING   = 2'd3
  } reg_idx_t;

  // Sample sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GLIDE,
    ST_MIX,
    ST_RUN,
    ST_OUT
  } state_t;

  // Glided mix is unsigned Q1.22, 0 .. 2^22.
  localparam int MIX_W  = 23;
  // Comb feedback gain is unsigned Q0.15, always below 1.0.
  localparam int GAIN_W = 15;

  localparam logic [MIX_W-1:0]  MIX_ONE    = 23'd4194304;
  localparam logic [MIX_W-1:0]  MIX_FLOOR  = 23'd4194;
  localparam logic signed [10:0] GLIDE_COEF = 11'sd655;
  localparam logic [15:0]       Q15_ONE    = 16'd32768;
  localparam logic [15:0]       ROOM_MIN   = 16'd16384;
  localparam logic [15:0]       ROOM_MAX   = 16'd31130;
  localparam logic [15:0]       DAMP_MIN   = 16'd3277;
  localparam logic [15:0]       DAMP_MAX   = 16'd26214;

  // Sequencer requests to the mix glide unit.
  typedef struct packed {
    logic mul;     // form the glide step and the comb gain product
    logic update;  // commit the new glided mix
  } glide_ctrl_t;

  // Glide unit results.
  typedef struct packed {
    logic              active;  // new mix lies above the pass-through floor
    logic [MIX_W-1:0]  mix;     // current glided mix
    logic [GAIN_W-1:0] gain;    // comb feedback gain
  } glide_stat_t;

endpackage

[design/crv_glide.sv]
// Mix glide and comb gain unit: holds the glided wet mix and derives the feedback gain.
// Depends on crv_pkg.

module crv_glide (
  input  logic                clk,
  input  logic                rst_n,
  input  crv_pkg::glide_ctrl_t ctrl,
  input  logic [15:0]         wet_mix,
  input  logic [15:0]         room_size,
  input  logic [15:0]         damping,
  output crv_pkg::glide_stat_t stat
);
  import crv_pkg::*;

  logic [MIX_W-1:0]        mix_r;
  logic signed [33:0]      step_r;
  logic [29:0]             gprod_r;

  logic [15:0]             wet_c;
  logic [MIX_W-1:0]        target;
  logic signed [MIX_W:0]   diff;
  logic signed [34:0]      prod;
  logic signed [33:0]      step_sum;
  logic signed [17:0]      delta;
  logic signed [24:0]      msum;
  logic [MIX_W-1:0]        mix_nxt;
  logic [15:0]             room_c;
  logic [15:0]             damp_c;
  logic [15:0]             damp_inv;
  logic [29:0]             gain_sum;

  // Glide step toward the target: 655/65536 of the remaining distance.
  always_comb begin
    wet_c  = (wet_mix > Q15_ONE) ? Q15_ONE : wet_mix;
    target = {wet_c, 7'b0};
    diff   = $signed({1'b0, target}) - $signed({1'b0, mix_r});
    prod   = diff * GLIDE_COEF;
  end

  // Rounded step added to the mix, then clamped to the Q1.22 range.
  always_comb begin
    step_sum = step_r + 34'sd32768;
    delta    = step_sum[33:16];
    msum     = $signed({2'b00, mix_r}) + {{7{delta[17]}}, delta};
    if (msum < 25'sd0) begin
      mix_nxt = '0;
    end else if (msum > $signed({2'b00, MIX_ONE})) begin
      mix_nxt = MIX_ONE;
    end else begin
      mix_nxt = msum[MIX_W-1:0];
    end
  end

  // Feedback gain from the clamped room size and damping.
  always_comb begin
    room_c = room_size;
    if (room_size < ROOM_MIN) room_c = ROOM_MIN;
    if (room_size > ROOM_MAX) room_c = ROOM_MAX;
    damp_c = damping;
    if (damping < DAMP_MIN) damp_c = DAMP_MIN;
    if (damping > DAMP_MAX) damp_c = DAMP_MAX;
    damp_inv = Q15_ONE - damp_c;
    gain_sum = gprod_r + 30'd16384;
  end

  // Both products are registered before use.
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      step_r  <= prod[33:0];
      gprod_r <= room_c[14:0] * damp_inv[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= '0;
    end else if (ctrl.update) begin
      mix_r <= mix_nxt;
    end
  end

  assign stat.active = (mix_nxt > MIX_FLOOR);
  assign stat.mix    = mix_r;
  assign stat.gain   = gain_sum[29:15];

endmodule

[design/comb_allpass_reverb_top.sv]
// Top level of the comb/allpass reverberator: sequencer, delay-line memories, mixer.
// Depends on crv_pkg and crv_glide.
//
// Usage:
// - Input channel (in_valid/in_ready) carries one Q1.15 sample and a block-end
//   marker per transaction; the result channel (out_valid/out_ready) returns
//   exactly one processed sample per input, with the marker copied through.
// - Samples are processed one at a time. With reverb active a sample passes
//   through the sequencer states glide, mix, run and out before the next input
//   is taken. The run phase is set by the four comb taps that share the single
//   comb memory port, the two allpass stages in series and the two mixer
//   multiplies. Below the mix floor the run state is skipped; with the block
//   disabled a sample goes from idle straight to out.
// - The result sits in an output register, so a stalled receiver does not
//   block the next input transaction; only the sample after that waits.
// - Reset loads the configuration defaults, clears the glided mix and resets all delay
//   line pointers. Delay lines need no clearing pass: each line carries a
//   wrap mark, and until its pointer first wraps, every tap reads as zero.
// - The APB port (pready always high) writes enable, wet mix, room size and
//   damping at byte addresses 0, 4, 8 and 12; reads return the values held.

module comb_allpass_reverb_top #(
  parameter int COMB_A_LEN    = 1729,
  parameter int COMB_B_LEN    = 1493,
  parameter int COMB_C_LEN    = 1791,
  parameter int COMB_D_LEN    = 2032,
  parameter int ALLPASS_A_LEN = 244,
  parameter int ALLPASS_B_LEN = 81
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_sample_in,
  input  logic                        in_block_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_sample_out,
  output logic                        out_block_end_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crv_pkg::ADDR_W-1:0]  paddr,
  input  logic [crv_pkg::DATA_W-1:0]  pwdata,
  output logic [crv_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import crv_pkg::*;

  // Delay-line memory layout: the four combs share one memory, the two
  // allpass lines another, each line in a contiguous address range.
  localparam int COMB_DEPTH = COMB_A_LEN + COMB_B_LEN + COMB_C_LEN + COMB_D_LEN;
  localparam int AP_DEPTH   = ALLPASS_A_LEN + ALLPASS_B_LEN;
  localparam int CAW        = $clog2(COMB_DEPTH);
  localparam int APW        = $clog2(AP_DEPTH);

  localparam int COMB_FIRST [4] = '{
    0,
    COMB_A_LEN,
    COMB_A_LEN + COMB_B_LEN,
    COMB_A_LEN + COMB_B_LEN + COMB_C_LEN
  };
  localparam int COMB_LAST [4] = '{
    COMB_A_LEN - 1,
    COMB_A_LEN + COMB_B_LEN - 1,
    COMB_A_LEN + COMB_B_LEN + COMB_C_LEN - 1,
    COMB_DEPTH - 1
  };
  localparam int AP_FIRST [2] = '{0, ALLPASS_A_LEN};
  localparam int AP_LAST  [2] = '{ALLPASS_A_LEN - 1, AP_DEPTH - 1};

  // Step schedule inside the run phase.
  localparam logic [3:0] S_CMB_RD_END  = 4'd3;
  localparam logic [3:0] S_CMB_MAC_BEG = 4'd1;
  localparam logic [3:0] S_CMB_MAC_END = 4'd4;
  localparam logic [3:0] S_CMB_WR_BEG  = 4'd2;
  localparam logic [3:0] S_CMB_WR_END  = 4'd5;
  localparam logic [3:0] S_APA_RD      = 4'd5;
  localparam logic [3:0] S_APA_WR      = 4'd6;
  localparam logic [3:0] S_APB_RD      = 4'd6;
  localparam logic [3:0] S_APB_WR      = 4'd7;
  localparam logic [3:0] S_WET_MUL     = 4'd8;
  localparam logic [3:0] S_MIX         = 4'd9;

  localparam logic signed [25:0] S24_MAX = 26'sd8388607;
  localparam logic signed [25:0] S24_MIN = -26'sd8388608;
  localparam logic signed [26:0] S16_MAX = 27'sd32767;
  localparam logic signed [26:0] S16_MIN = -27'sd32768;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) begin
      r = S24_MAX[23:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[23:0];
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = S16_MAX[15:0];
    end else if (v < S16_MIN) begin
      r = S16_MIN[15:0];
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Half of a value, rounded half up.
  function automatic logic signed [23:0] half_rnd(input logic signed [23:0] v);
    logic signed [24:0] t;
    t = {v[23], v} + 25'sd1;
    return t[24:1];
  endfunction

  function automatic logic signed [25:0] ext26(input logic signed [23:0] v);
    return {{2{v[23]}}, v};
  endfunction

  // Configuration registers.
  logic        enable_r;
  logic [15:0] wet_mix_r;
  logic [15:0] room_size_r;
  logic [15:0] damping_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // Sequencer.
  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic        run;
  logic        out_load;
  glide_ctrl_t gctl;
  glide_stat_t gstat;

  // Sample payload.
  logic signed [15:0] x_r;
  logic               be_r;
  logic signed [15:0] y_r;
  logic               out_valid_r;
  logic signed [15:0] out_sample_r;
  logic               out_be_r;

  // Comb memory and its pointers.
  logic signed [23:0] comb_mem [COMB_DEPTH];
  logic signed [23:0] comb_q_r;
  logic [CAW-1:0]     comb_ptr_r [4];
  logic [3:0]         comb_wrap_r;
  logic               c_ok_r;
  logic [CAW-1:0]     caddr1_r, caddr2_r;
  logic               crd_en, cmac_en, cwr_en;
  logic [1:0]         ck;
  logic [CAW-1:0]     crd_addr;
  logic signed [23:0] c_val;
  logic signed [39:0] cmul_r;
  logic signed [39:0] cm_rnd;
  logic signed [23:0] cwr_data;
  logic signed [25:0] sum_r;
  logic signed [25:0] avg_sum;

  // Allpass memory and its pointers.
  logic signed [23:0] ap_mem [AP_DEPTH];
  logic signed [23:0] ap_q_r;
  logic [APW-1:0]     ap_ptr_r [2];
  logic [1:0]         ap_wrap_r;
  logic               a_ok_r;
  logic [APW-1:0]     aaddr1_r;
  logic               ard_en, awr_en;
  logic               ak;
  logic [APW-1:0]     ard_addr;
  logic signed [23:0] ap_in;
  logic signed [23:0] d_val;
  logic signed [23:0] awr_data;
  logic signed [23:0] ap_out;
  logic signed [23:0] avg_r;
  logic signed [23:0] wet_r;

  // Mixer.
  logic signed [39:0] p1_r;
  logic signed [47:0] p2_r;
  logic signed [48:0] mix_sum;

  // APB register file; writes complete in the access phase.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      wet_mix_r   <= 16'd0;
      room_size_r <= 16'd26214;
      damping_r   <= 16'd16384;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:    enable_r    <= pwdata[0];
        REG_WET_MIX:   wet_mix_r   <= pwdata[15:0];
        REG_ROOM_SIZE: room_size_r <= pwdata[15:0];
        REG_DAMPING:   damping_r   <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, enable_r};
      REG_WET_MIX:   prdata = {{(DATA_W-16){1'b0}}, wet_mix_r};
      REG_ROOM_SIZE: prdata = {{(DATA_W-16){1'b0}}, room_size_r};
      REG_DAMPING:   prdata = {{(DATA_W-16){1'b0}}, damping_r};
    endcase
  end

  // Mix glide and feedback gain.
  crv_glide u_glide (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (gctl),
    .wet_mix   (wet_mix_r),
    .room_size (room_size_r),
    .damping   (damping_r),
    .stat      (gstat)
  );

  // Sequencer next state and unit requests.
  always_comb begin
    state_nxt = state_r;
    gctl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = enable_r ? ST_GLIDE : ST_OUT;
      end
      ST_GLIDE: begin
        gctl.mul  = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        gctl.update = 1'b1;
        state_nxt   = gstat.active ? ST_RUN : ST_OUT;
      end
      ST_RUN: begin
        if (cnt_r == S_MIX) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign run      = (state_r == ST_RUN);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MIX) begin
        cnt_r <= '0;
      end else if (run) begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  // Comb taps: one read per step, multiply-accumulate a step later, write-back after that.
  always_comb begin
    crd_en   = run && (cnt_r <= S_CMB_RD_END);
    cmac_en  = run && (cnt_r >= S_CMB_MAC_BEG) && (cnt_r <= S_CMB_MAC_END);
    cwr_en   = run && (cnt_r >= S_CMB_WR_BEG) && (cnt_r <= S_CMB_WR_END);
    ck       = cnt_r[1:0];
    crd_addr = comb_ptr_r[ck];
    c_val    = c_ok_r ? comb_q_r : 24'sd0;
    cm_rnd   = (cmul_r + 40'sd16384) >>> 15;
    cwr_data = sat24({{10{x_r[15]}}, x_r} + cm_rnd[25:0]);
    avg_sum  = sum_r + 26'sd2;
  end

  // Allpass stages in series, each a read then a write-back a step later.
  always_comb begin
    ard_en   = run && ((cnt_r == S_APA_RD) || (cnt_r == S_APB_RD));
    awr_en   = run && ((cnt_r == S_APA_WR) || (cnt_r == S_APB_WR));
    ak       = (cnt_r == S_APB_RD);
    ard_addr = ap_ptr_r[ak];
    ap_in    = (cnt_r == S_APA_WR) ? avg_r : wet_r;
    d_val    = a_ok_r ? ap_q_r : 24'sd0;
    awr_data = sat24(ext26(ap_in) + ext26(half_rnd(d_val)));
    ap_out   = sat24(ext26(d_val) - ext26(half_rnd(ap_in)));
    mix_sum  = {{9{p1_r[39]}}, p1_r} + {p2_r[47], p2_r} + 49'sd2097152;
  end

  // Delay-line memories, registered read.
  always_ff @(posedge clk) begin
    if (crd_en) comb_q_r <= comb_mem[crd_addr];
    if (cwr_en) comb_mem[caddr2_r] <= cwr_data;
  end

  always_ff @(posedge clk) begin
    if (ard_en) ap_q_r <= ap_mem[ard_addr];
    if (awr_en) ap_mem[aaddr1_r] <= awr_data;
  end

  // Line pointers advance at each read; a line's first wrap marks it filled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        comb_ptr_r[k] <= CAW'(COMB_FIRST[k]);
      end
      for (int k = 0; k < 2; k++) begin
        ap_ptr_r[k] <= APW'(AP_FIRST[k]);
      end
      comb_wrap_r <= '0;
      ap_wrap_r   <= '0;
      c_ok_r      <= 1'b0;
      a_ok_r      <= 1'b0;
    end else begin
      if (crd_en) begin
        c_ok_r <= comb_wrap_r[ck];
        if (crd_addr == CAW'(COMB_LAST[ck])) begin
          comb_ptr_r[ck]  <= CAW'(COMB_FIRST[ck]);
          comb_wrap_r[ck] <= 1'b1;
        end else begin
          comb_ptr_r[ck] <= crd_addr + 1'b1;
        end
      end
      if (ard_en) begin
        a_ok_r <= ap_wrap_r[ak];
        if (ard_addr == APW'(AP_LAST[ak])) begin
          ap_ptr_r[ak]  <= APW'(AP_FIRST[ak]);
          ap_wrap_r[ak] <= 1'b1;
        end else begin
          ap_ptr_r[ak] <= ard_addr + 1'b1;
        end
      end
    end
  end

  // Sample datapath.
  always_ff @(posedge clk) begin
    caddr1_r <= crd_addr;
    caddr2_r <= caddr1_r;
    aaddr1_r <= ard_addr;
    if (in_valid && in_ready) begin
      x_r  <= in_sample_in;
      be_r <= in_block_end;
      y_r  <= in_sample_in;
    end
    if (cmac_en) begin
      cmul_r <= c_val * $signed({1'b0, gstat.gain});
      sum_r  <= ((cnt_r == S_CMB_MAC_BEG) ? 26'sd0 : sum_r) + ext26(c_val);
    end
    if (run && (cnt_r == S_APA_RD)) begin
      avg_r <= avg_sum[25:2];
      p1_r  <= x_r * $signed({1'b0, MIX_ONE - gstat.mix});
    end
    if (awr_en) wet_r <= ap_out;
    if (run && (cnt_r == S_WET_MUL)) begin
      p2_r <= wet_r * $signed({1'b0, gstat.mix});
    end
    if (run && (cnt_r == S_MIX)) begin
      y_r <= sat16(mix_sum[48:22]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= y_r;
      out_be_r     <= be_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_block_end_out = out_be_r;

endmodule

[design/crv_checker.sv]
// Port-level checker for the reverberator top level, with its bind statement.
// Depends on comb_allpass_reverb_top.

module crv_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample_out,
  input logic               out_block_end_out
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
                                && $stable(out_block_end_out))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // One sample at a time: the cycle after a transaction takes no input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in progress");

  // A new result appears exactly as the sequencer returns to idle.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result delivered without freeing the input");

endmodule

bind comb_allpass_reverb_top crv_port_checker u_crv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sample_out    (out_sample_out),
  .out_block_end_out (out_block_end_out)
);

[verif/crv_checker.sv]
// Scoreboard for the comb/allpass reverberator: tracks register writes, predicts each
// processed sample and compares it with the result channel. Depends on crv_pkg.
`timescale 1ns / 1ps

module crv_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [15:0]          in_sample_in,
  input  logic                        in_block_end,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [15:0]          out_sample_out,
  input  logic                        out_block_end_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [crv_pkg::ADDR_W-1:0]  paddr,
  input  logic [crv_pkg::DATA_W-1:0]  pwdata,
  output int                          errors,
  output int                          pending
);
  import crv_pkg::*;

  // Delay line counts and fixed-point limits of the reverb.
  localparam int  COMB_TAPS     = 4;
  localparam int  ALLPASS_TAPS  = 2;
  localparam longint UNITY_MIX  = 64'd4194304;
  localparam longint MIX_LOW    = 64'd4194;
  localparam longint GLIDE_STEP = 64'd655;
  localparam longint WORD_MAX   = 64'sd8388607;
  localparam longint WORD_MIN   = -64'sd8388608;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               block_end;
  } audio_t;

  // Shadow copy of the block's registers and state.
  logic        cfg_enable;
  logic [15:0] cfg_wet;
  logic [15:0] cfg_room;
  logic [15:0] cfg_damp;
  int          comb_mem    [COMB_TAPS][2048];
  int          allpass_mem [ALLPASS_TAPS][256];
  int          comb_ptr    [COMB_TAPS];
  int          allpass_ptr [ALLPASS_TAPS];
  longint      glide;

  audio_t expected_audio [$];

  function automatic int comb_length(int k);
    case (k)
      0:       return 1729;
      1:       return 1493;
      2:       return 1791;
      default: return 2032;
    endcase
  endfunction

  function automatic int allpass_length(int k);
    return (k == 0) ? 244 : 81;
  endfunction

  // Round half up, then drop sh fraction bits.
  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One feedback comb: read the delayed word, write input plus scaled feedback.
  function automatic longint comb_stage(int k, longint x, longint g);
    longint c;
    c = comb_mem[k][comb_ptr[k]];
    comb_mem[k][comb_ptr[k]] = int'(clamp(x + round_shift(c * g, 15), WORD_MIN, WORD_MAX));
    comb_ptr[k] = (comb_ptr[k] + 1 >= comb_length(k)) ? 0 : comb_ptr[k] + 1;
    return c;
  endfunction

  // One allpass section with gain one half.
  function automatic longint allpass_stage(int k, longint x);
    longint d;
    d = allpass_mem[k][allpass_ptr[k]];
    allpass_mem[k][allpass_ptr[k]] = int'(clamp(x + round_shift(d, 1), WORD_MIN, WORD_MAX));
    allpass_ptr[k] = (allpass_ptr[k] + 1 >= allpass_length(k)) ? 0 : allpass_ptr[k] + 1;
    return clamp(d - round_shift(x, 1), WORD_MIN, WORD_MAX);
  endfunction

  // Processed sample for one input transaction; advances the shadow state.
  function automatic audio_t reverb_sample(logic signed [15:0] s, logic be);
    longint x, y, target, room, damp, g, sum, avg, wet;
    audio_t r;
    x = s;
    y = x;
    if (cfg_enable) begin
      target = clamp(longint'(cfg_wet), 0, 32768) * 128;
      glide += round_shift(GLIDE_STEP * (target - glide), 16);
      glide = clamp(glide, 0, UNITY_MIX);
      if (glide > MIX_LOW) begin
        room = clamp(longint'(cfg_room), 16384, 31130);
        damp = clamp(longint'(cfg_damp), 3277, 26214);
        g = round_shift(room * (32768 - damp), 15);
        sum = 0;
        for (int k = 0; k < COMB_TAPS; k++) sum += comb_stage(k, x, g);
        avg = round_shift(sum, 2);
        wet = allpass_stage(0, avg);
        wet = allpass_stage(1, wet);
        y = clamp(round_shift(x * (UNITY_MIX - glide) + wet * glide, 22), -32768, 32767);
      end
    end
    r.sample = y[15:0];
    r.block_end = be;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    audio_t want;
    if (!rst_n) begin
      cfg_enable = 1'b0;
      cfg_wet    = 16'd0;
      cfg_room   = 16'd26214;
      cfg_damp   = 16'd16384;
      glide      = 0;
      foreach (comb_mem[k, i]) comb_mem[k][i] = 0;
      foreach (allpass_mem[k, i]) allpass_mem[k][i] = 0;
      foreach (comb_ptr[k]) comb_ptr[k] = 0;
      foreach (allpass_ptr[k]) allpass_ptr[k] = 0;
      expected_audio.delete();
      errors = 0;
    end else begin
      // Register writes complete in the access phase.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_ENABLE:    cfg_enable = pwdata[0];
          REG_WET_MIX:   cfg_wet    = pwdata[15:0];
          REG_ROOM_SIZE: cfg_room   = pwdata[15:0];
          REG_DAMPING:   cfg_damp   = pwdata[15:0];
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_audio.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, actual sample %0d end %0b",
                   $time, out_sample_out, out_block_end_out);
        end else begin
          want = expected_audio.pop_front();
          if (want.sample !== out_sample_out) begin
            errors++;
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want.sample, out_sample_out);
          end
          if (want.block_end !== out_block_end_out) begin
            errors++;
            $display("%0t: block_end_out mismatch: expected %0b, actual %0b",
                     $time, want.block_end, out_block_end_out);
          end
        end
      end

      // Predict the result of each accepted input transaction.
      if (in_valid && in_ready)
        expected_audio.insert(expected_audio.size(), reverb_sample(in_sample_in, in_block_end));
    end
    pending = expected_audio.size();
  end

endmodule

[verif/tb_comb_allpass_reverb_top.sv]
// Testbench top for comb_allpass_reverb_top: clock, reset, APB register writes, sample
// stimulus with varied flow control, watchdog and verdict. Depends on crv_pkg, crv_checker.
`timescale 1ns / 1ps

module tb_comb_allpass_reverb_top;
  import crv_pkg::*;

  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic signed [15:0]  in_sample_in;
  logic                in_block_end;
  logic                out_valid;
  logic                out_ready;
  logic signed [15:0]  out_sample_out;
  logic                out_block_end_out;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int                  errors;
  int                  pending;
  logic                in_taken = 1'b0;
  int                  send_pct = 0;
  int                  stall_pct = 0;
  int                  quiet = 0;

  comb_allpass_reverb_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_in(in_sample_in), .in_block_end(in_block_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_out(out_sample_out), .out_block_end_out(out_block_end_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  crv_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_in(in_sample_in), .in_block_end(in_block_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_out(out_sample_out), .out_block_end_out(out_block_end_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Input transaction flag, seen by the driver at the following falling edge.
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // Receiver stalls at random with the current stall percentage.
  always @(negedge clk) out_ready <= ($urandom_range(99, 0) >= stall_pct);

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Wait until every predicted result has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic program_reverb(logic en, int wet, int room, int damp);
    drain();
    reg_write(REG_ENABLE, {31'd0, en});
    reg_write(REG_WET_MIX, wet);
    reg_write(REG_ROOM_SIZE, room);
    reg_write(REG_DAMPING, damp);
  endtask

  // One input transaction, preceded by random idle cycles.
  task automatic push_sample(logic signed [15:0] s, logic be);
    while ($urandom_range(99, 0) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_block_end <= be;
    do @(negedge clk); while (!in_taken);
  endtask

  // Mostly full-range audio, with some quiet passages and full-scale peaks.
  function automatic logic signed [15:0] audio_value();
    case ($urandom_range(9, 0))
      0:       return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
      1, 2, 3: return 16'($urandom_range(512, 0) - 256);
      default: return 16'($urandom_range(65535, 0));
    endcase
  endfunction

  task automatic run_phase(logic en, int wet, int room, int damp, int count,
                           int sidle, int rstall, bit drain_mid);
    program_reverb(en, wet, room, damp);
    send_pct  = sidle;
    stall_pct = rstall;
    for (int i = 0; i < count; i++) begin
      if (drain_mid && i == count / 2) drain();
      push_sample(audio_value(), $urandom_range(7, 0) == 0);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_block_end = 1'b0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Disabled after reset: samples pass unchanged.
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh0000, 1'b0);
    push_sample(-16'sd1, 1'b1);

    // Enabled with zero mix: the glided mix stays under the floor.
    program_reverb(1'b1, 0, 26214, 16384);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b1);
    push_sample(16'sd12345, 1'b0);

    // Fully wet with room above range and damping below range.
    program_reverb(1'b1, 32768, 65535, 0);
    for (int i = 0; i < 4; i++) push_sample(16'sh7fff, i[0]);
    for (int i = 0; i < 4; i++) push_sample(16'sh8000, i[0]);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd1, 1'b1);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sh7fff, 1'b1);

    // Wet mix above full scale acts as full scale.
    program_reverb(1'b1, 65535, 65535, 0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b0);

    // Random passages over several settings and flow-control patterns.
    run_phase(1'b1, 32768, 26214, 16384, 300, 0, 0, 1'b1);
    run_phase(1'b1, 65535, 0, 65535, 200, 88, 0, 1'b0);
    run_phase(1'b1, 3000, 65535, 0, 200, 0, 88, 1'b0);
    run_phase(1'b0, 40, 20000, 9000, 50, 15, 15, 1'b0);
    run_phase(1'b1, 0, 20000, 9000, 600, 0, 0, 1'b0);
    run_phase(1'b1, 30, 31130, 3277, 50, 15, 15, 1'b0);
    run_phase(1'b1, $urandom_range(65535, 0), $urandom_range(65535, 0),
              $urandom_range(65535, 0), 130, 88, 0, 1'b0);
    run_phase(1'b1, 32768, $urandom_range(65535, 0), $urandom_range(65535, 0),
              150, 0, 88, 1'b0);

    // Let the last results drain, then allow for the block's latency.
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
